// ===== rtl/link_frame_mode_debounce_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the link frame mode debounce block
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef LINK_FRAME_MODE_DEBOUNCE_TOP_ASSERT_SVH
`define LINK_FRAME_MODE_DEBOUNCE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge, switched off while reset is low.
`define LFMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every rising edge, reset included.
`define LFMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LFMD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/lfmd_pkg.sv =====
// ---------------------------------------------------------------------------
// lfmd_pkg
// Shared constants, register indexes and types of the link frame block.
// ---------------------------------------------------------------------------
`default_nettype none

package lfmd_pkg;

  localparam logic [15:0] FRAME_BYTES   = 16'd11;
  localparam logic [7:0]  HEADER_MARK   = 8'hAA;
  localparam logic [7:0]  TAIL_MARK     = 8'h55;
  localparam logic [7:0]  CAND_CNT_MAX  = 8'd255;
  localparam logic [15:0] FRAME_CNT_MAX = 16'hFFFF;
  localparam logic [7:0]  MODE_TARGET   = 8'd1;
  localparam logic [7:0]  MODE_IDLE     = 8'd0;

  localparam logic [7:0]  RST_CONFIRM_01 = 8'd3;
  localparam logic [7:0]  RST_CONFIRM_10 = 8'd3;
  localparam logic [15:0] RST_TIMEOUT    = 16'd100;
  localparam logic [9:0]  RST_WINDOW     = 10'd1000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONFIRM_01 = 2'd0,
    CFG_CONFIRM_10 = 2'd1,
    CFG_TIMEOUT    = 2'd2,
    CFG_WINDOW     = 2'd3
  } cfg_idx_t;

  // Live configuration register values.
  typedef struct packed {
    logic [7:0]  confirm_01;
    logic [7:0]  confirm_10;
    logic [15:0] timeout;
    logic [9:0]  window;
  } cfg_t;

  // Classification of the item held in the input register.
  typedef struct packed {
    logic frame_good;
    logic tick_live;
    logic tick_clear;
  } step_kind_t;

endpackage

`default_nettype wire

// ===== rtl/link_frame_mode_debounce_top.sv =====
// ---------------------------------------------------------------------------
// link_frame_mode_debounce_top
// Link frame checker with mode debounce, online watchdog and rate meter.
// ---------------------------------------------------------------------------
// Each input transfer carries either a received frame (in_mode low) or a one
// millisecond tick (in_mode high), and every transfer, accepted frame or
// rejected one, produces exactly one result transfer. The block takes one
// item per clock cycle for as long as the result side keeps up: the item is
// captured in an input register, the whole state update is done by
// combinational compare and increment logic, and the updated state registers
// are themselves the result register. out_valid rises as they take the
// update of the input register's item, held there while an earlier result
// waits. While a result waits on out_ready the input register can still
// take one further item, after which in_ready falls. Configuration writes
// are always accepted (cfg_ready is tied high) and must only be made while
// no item is in flight. There is no clearing pass after reset.
`default_nettype none

module link_frame_mode_debounce_top
  import lfmd_pkg::*;
#(
  parameter logic [15:0] FRAME_LEN = FRAME_BYTES
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_mode,
  input  wire logic [15:0]           in_frame_length,
  input  wire logic [7:0]            in_header_byte,
  input  wire logic [7:0]            in_tail_byte,
  input  wire logic [7:0]            in_target_mode,
  input  wire logic [31:0]           in_yaw_bits,
  input  wire logic [31:0]           in_pitch_bits,
  input  wire logic [31:0]           in_time_now,
  input  wire logic                  in_system_ready,
  input  wire logic                  in_vision_ready,
  input  wire logic                  in_auto_ready,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_online,
  output logic                       out_detected,
  output logic [7:0]                 out_link_mode,
  output logic [31:0]                out_yaw_out,
  output logic [31:0]                out_pitch_out,
  output logic [15:0]                out_frame_rate,
  // Configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Input register: the item waiting for its state update.
  logic        in_valid_r, in_valid_nxt;
  logic        mode_r;
  logic [15:0] frame_length_r;
  logic [7:0]  header_byte_r;
  logic [7:0]  tail_byte_r;
  logic [7:0]  target_mode_r;
  logic [31:0] yaw_bits_r;
  logic [31:0] pitch_bits_r;
  logic [31:0] time_now_r;
  logic        system_ready_r;
  logic        vision_ready_r;
  logic        auto_ready_r;

  logic        out_valid_r, out_valid_nxt;
  cfg_t        cfg_r, cfg_nxt;
  logic        step_en;
  logic        in_take;
  step_kind_t  kind;

  // The held item moves on when the result slot is empty or being emptied;
  // the state registers then update and present the new result.
  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (step_en ? 1'b0 : in_valid_r);
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r         <= in_mode;
      frame_length_r <= in_frame_length;
      header_byte_r  <= in_header_byte;
      tail_byte_r    <= in_tail_byte;
      target_mode_r  <= in_target_mode;
      yaw_bits_r     <= in_yaw_bits;
      pitch_bits_r   <= in_pitch_bits;
      time_now_r     <= in_time_now;
      system_ready_r <= in_system_ready;
      vision_ready_r <= in_vision_ready;
      auto_ready_r   <= in_auto_ready;
    end
  end

  // Configuration registers. Every index of the port maps to a register, and
  // each takes only as many low bits of the data as it is wide.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CONFIRM_01: cfg_nxt.confirm_01 = cfg_data[7:0];
        CFG_CONFIRM_10: cfg_nxt.confirm_10 = cfg_data[7:0];
        CFG_TIMEOUT:    cfg_nxt.timeout    = cfg_data[15:0];
        CFG_WINDOW:     cfg_nxt.window     = cfg_data[9:0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.confirm_01 <= RST_CONFIRM_01;
      cfg_r.confirm_10 <= RST_CONFIRM_10;
      cfg_r.timeout    <= RST_TIMEOUT;
      cfg_r.window     <= RST_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Frame validation: ready flags, exact length and both framing bytes.
  lfmd_frame_check #(
    .FRAME_LEN (FRAME_LEN)
  ) u_check (
    .item_mode    (mode_r),
    .frame_length (frame_length_r),
    .header_byte  (header_byte_r),
    .tail_byte    (tail_byte_r),
    .system_ready (system_ready_r),
    .vision_ready (vision_ready_r),
    .auto_ready   (auto_ready_r),
    .kind         (kind)
  );

  // Link state and debounce; its registers double as the result register.
  lfmd_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .kind           (kind),
    .cfg            (cfg_r),
    .target_mode    (target_mode_r),
    .yaw_bits       (yaw_bits_r),
    .pitch_bits     (pitch_bits_r),
    .time_now       (time_now_r),
    .online         (out_online),
    .detected       (out_detected),
    .link_mode      (out_link_mode),
    .yaw_out        (out_yaw_out),
    .pitch_out      (out_pitch_out),
    .frame_rate     (out_frame_rate)
  );

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/lfmd_frame_check.sv =====
// ---------------------------------------------------------------------------
// lfmd_frame_check
// Decodes the registered item into good frame, live tick or clearing tick.
// ---------------------------------------------------------------------------
`default_nettype none

module lfmd_frame_check
  import lfmd_pkg::*;
#(
  parameter logic [15:0] FRAME_LEN = FRAME_BYTES
)
(
  input  wire logic        item_mode,
  input  wire logic [15:0] frame_length,
  input  wire logic [7:0]  header_byte,
  input  wire logic [7:0]  tail_byte,
  input  wire logic        system_ready,
  input  wire logic        vision_ready,
  input  wire logic        auto_ready,
  output step_kind_t       kind
);

  logic flags_ok;
  logic framing_ok;

  assign flags_ok   = system_ready && vision_ready && auto_ready;
  assign framing_ok = (frame_length == FRAME_LEN) && (header_byte == HEADER_MARK)
                      && (tail_byte == TAIL_MARK);

  // A frame that fails any check leaves all state untouched.
  always_comb begin
    kind.frame_good = !item_mode && flags_ok && framing_ok;
    kind.tick_live  = item_mode && system_ready;
    kind.tick_clear = item_mode && !system_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/lfmd_state.sv =====
// ---------------------------------------------------------------------------
// lfmd_state
// Link state, mode debounce, online watchdog and frame-rate window registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "link_frame_mode_debounce_top_assert.svh"

module lfmd_state
  import lfmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire step_kind_t  kind,
  input  wire cfg_t        cfg,
  input  wire logic [7:0]  target_mode,
  input  wire logic [31:0] yaw_bits,
  input  wire logic [31:0] pitch_bits,
  input  wire logic [31:0] time_now,
  output logic             online,
  output logic             detected,
  output logic [7:0]       link_mode,
  output logic [31:0]      yaw_out,
  output logic [31:0]      pitch_out,
  output logic [15:0]      frame_rate
);

  logic [31:0] online_stamp_r, online_stamp_nxt;
  logic        rx_seen_r, rx_seen_nxt;
  logic        online_r, online_nxt;
  logic        detected_r, detected_nxt;
  logic [7:0]  settled_r, settled_nxt;
  logic [7:0]  cand_mode_r, cand_mode_nxt;
  logic [7:0]  cand_cnt_r, cand_cnt_nxt;
  logic [31:0] held_yaw_r, held_yaw_nxt;
  logic [31:0] held_pitch_r, held_pitch_nxt;
  logic [31:0] yaw_r, yaw_nxt;
  logic [31:0] pitch_r, pitch_nxt;
  logic [15:0] frame_cnt_r, frame_cnt_nxt;
  logic [15:0] rate_r, rate_nxt;
  logic [9:0]  window_r, window_nxt;

  // Debounce values for a good frame.
  logic [7:0]  db_cnt;
  logic [7:0]  db_need;
  logic [7:0]  db_settled;
  logic [31:0] db_held_yaw;
  logic [31:0] db_held_pitch;
  logic [9:0]  window_inc;
  logic [31:0] elapsed;

  // Short names for the assertion expressions below.
  logic        frame_step;
  logic        frame_cnt_full;

  always_comb begin
    if (target_mode == cand_mode_r) begin
      db_cnt = (cand_cnt_r == CAND_CNT_MAX) ? cand_cnt_r : cand_cnt_r + 8'd1;
    end else begin
      db_cnt = 8'd1;
    end
    if ((settled_r == MODE_IDLE) && (target_mode == MODE_TARGET)) begin
      db_need = cfg.confirm_01;
    end else if ((settled_r == MODE_TARGET) && (target_mode == MODE_IDLE)) begin
      db_need = cfg.confirm_10;
    end else begin
      db_need = 8'd1;
    end
    db_settled    = (db_cnt >= db_need) ? target_mode : settled_r;
    db_held_yaw   = (target_mode == MODE_TARGET) ? yaw_bits : held_yaw_r;
    db_held_pitch = (target_mode == MODE_TARGET) ? pitch_bits : held_pitch_r;
  end

  assign window_inc = window_r + 10'd1;
  assign elapsed    = time_now - online_stamp_r;

  always_comb begin
    online_stamp_nxt = online_stamp_r;
    rx_seen_nxt      = rx_seen_r;
    online_nxt       = online_r;
    detected_nxt     = detected_r;
    settled_nxt      = settled_r;
    cand_mode_nxt    = cand_mode_r;
    cand_cnt_nxt     = cand_cnt_r;
    held_yaw_nxt     = held_yaw_r;
    held_pitch_nxt   = held_pitch_r;
    yaw_nxt          = yaw_r;
    pitch_nxt        = pitch_r;
    frame_cnt_nxt    = frame_cnt_r;
    rate_nxt         = rate_r;
    window_nxt       = window_r;
    if (step_en) begin
      if (kind.frame_good) begin
        online_stamp_nxt = time_now;
        rx_seen_nxt      = 1'b1;
        online_nxt       = 1'b1;
        if (frame_cnt_r != FRAME_CNT_MAX) begin
          frame_cnt_nxt = frame_cnt_r + 16'd1;
        end
        cand_mode_nxt  = target_mode;
        cand_cnt_nxt   = db_cnt;
        settled_nxt    = db_settled;
        held_yaw_nxt   = db_held_yaw;
        held_pitch_nxt = db_held_pitch;
        if (db_settled == MODE_TARGET) begin
          detected_nxt = 1'b1;
          yaw_nxt      = yaw_bits;
          pitch_nxt    = pitch_bits;
        end else begin
          detected_nxt = 1'b0;
          yaw_nxt      = db_held_yaw;
          pitch_nxt    = db_held_pitch;
        end
      end else if (kind.tick_clear) begin
        online_stamp_nxt = 32'd0;
        rx_seen_nxt      = 1'b0;
        online_nxt       = 1'b0;
        detected_nxt     = 1'b0;
        frame_cnt_nxt    = 16'd0;
        rate_nxt         = 16'd0;
        window_nxt       = 10'd0;
      end else if (kind.tick_live) begin
        if (window_inc >= cfg.window) begin
          rate_nxt      = frame_cnt_r;
          frame_cnt_nxt = 16'd0;
          window_nxt    = 10'd0;
        end else begin
          window_nxt = window_inc;
        end
        if (!rx_seen_r) begin
          online_nxt   = 1'b0;
          detected_nxt = 1'b0;
        end else if (elapsed <= {16'd0, cfg.timeout}) begin
          online_nxt = 1'b1;
        end else begin
          rx_seen_nxt  = 1'b0;
          online_nxt   = 1'b0;
          detected_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_stamp_r <= '0;
      rx_seen_r      <= 1'b0;
      online_r       <= 1'b0;
      detected_r     <= 1'b0;
      settled_r      <= '0;
      cand_mode_r    <= '0;
      cand_cnt_r     <= '0;
      held_yaw_r     <= '0;
      held_pitch_r   <= '0;
      yaw_r          <= '0;
      pitch_r        <= '0;
      frame_cnt_r    <= '0;
      rate_r         <= '0;
      window_r       <= '0;
    end else begin
      online_stamp_r <= online_stamp_nxt;
      rx_seen_r      <= rx_seen_nxt;
      online_r       <= online_nxt;
      detected_r     <= detected_nxt;
      settled_r      <= settled_nxt;
      cand_mode_r    <= cand_mode_nxt;
      cand_cnt_r     <= cand_cnt_nxt;
      held_yaw_r     <= held_yaw_nxt;
      held_pitch_r   <= held_pitch_nxt;
      yaw_r          <= yaw_nxt;
      pitch_r        <= pitch_nxt;
      frame_cnt_r    <= frame_cnt_nxt;
      rate_r         <= rate_nxt;
      window_r       <= window_nxt;
    end
  end

  assign online         = online_r;
  assign detected       = detected_r;
  assign link_mode      = settled_r;
  assign yaw_out        = yaw_r;
  assign pitch_out      = pitch_r;
  assign frame_rate     = rate_r;

  assign frame_step     = step_en && kind.frame_good;
  assign frame_cnt_full = (frame_cnt_r == FRAME_CNT_MAX);

  // Detection is only ever reported on a link that is online.
  `LFMD_ASSERT_ALWAYS(a_det_online, clk, rst_n && detected_r |-> online_r, "detected offline")
  // The online flag is only raised once a good frame has been seen.
  `LFMD_ASSERT(a_online_seen, clk, rst_n, online_r |-> rx_seen_r, "online without frame")
  // A full frame counter stays full on a further good frame.
  `LFMD_ASSERT(a_frame_cnt_sat, clk, rst_n, frame_step && frame_cnt_full |=> frame_cnt_full, "wrap")
  // After a good frame the debounce always holds a live candidate.
  `LFMD_ASSERT(a_cand_cnt_live, clk, rst_n, frame_step |=> cand_cnt_r != 8'd0, "count zero")

endmodule

`default_nettype wire

// ===== verif/lfmd_link_checker.sv =====
// ---------------------------------------------------------------------------
// lfmd_link_checker
// Watches the three channels of the link frame block, keeps its own copy of
// the link state and registers, and compares every result with the status
// predicted for the oldest outstanding input transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module lfmd_link_checker
  import lfmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_mode,
  input  logic [15:0]           in_frame_length,
  input  logic [7:0]            in_header_byte,
  input  logic [7:0]            in_tail_byte,
  input  logic [7:0]            in_target_mode,
  input  logic [31:0]           in_yaw_bits,
  input  logic [31:0]           in_pitch_bits,
  input  logic [31:0]           in_time_now,
  input  logic                  in_system_ready,
  input  logic                  in_vision_ready,
  input  logic                  in_auto_ready,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_online,
  input  logic                  out_detected,
  input  logic [7:0]            out_link_mode,
  input  logic [31:0]           out_yaw_out,
  input  logic [31:0]           out_pitch_out,
  input  logic [15:0]           out_frame_rate,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked
);

  localparam logic ITEM_TICK = 1'b1;

  typedef struct packed {
    logic        online;
    logic        detected;
    logic [7:0]  mode;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [15:0] rate;
  } link_status_t;

  // Register copy and link state.
  cfg_t        regs;
  logic [31:0] last_good_time;
  logic        frame_seen;
  logic        link_up;
  logic        locked;
  logic [7:0]  mode_settled;
  logic [7:0]  mode_cand;
  logic [7:0]  cand_run;
  logic [31:0] hold_yaw;
  logic [31:0] hold_pitch;
  logic [31:0] yaw_w;
  logic [31:0] pitch_w;
  logic [15:0] good_frames;
  logic [15:0] rate_w;
  logic [9:0]  win_ticks;

  link_status_t expected_status_q[$];
  int mismatches = 0;
  int waiting    = 0;
  int checked    = 0;

  assign fail_count      = mismatches;
  assign pending         = waiting;
  assign results_checked = checked;

  // Applies one accepted item to the link state and returns the status that
  // the block must then report.
  function automatic link_status_t advance_link(
    logic kind, logic [15:0] len, logic [7:0] hdr, logic [7:0] tail, logic [7:0] tgt,
    logic [31:0] yaw, logic [31:0] pitch, logic [31:0] now,
    logic sys, logic vis, logic aut
  );
    logic [7:0]   need;
    logic [31:0]  age;
    link_status_t st;
    if (kind == ITEM_TICK) begin
      if (!sys) begin
        // A tick without the system ready flag drops the link and the meter,
        // but the debounce and the angle words survive.
        last_good_time = '0;
        frame_seen     = 1'b0;
        link_up        = 1'b0;
        locked         = 1'b0;
        good_frames    = '0;
        rate_w         = '0;
        win_ticks      = '0;
      end else begin
        win_ticks = win_ticks + 10'd1;
        if (win_ticks >= regs.window) begin
          rate_w      = good_frames;
          good_frames = '0;
          win_ticks   = '0;
        end
        age = now - last_good_time;
        if (!frame_seen) begin
          link_up = 1'b0;
          locked  = 1'b0;
        end else if (age <= {16'd0, regs.timeout}) begin
          link_up = 1'b1;
        end else begin
          frame_seen = 1'b0;
          link_up    = 1'b0;
          locked     = 1'b0;
        end
      end
    end else if (len == FRAME_BYTES && sys && vis && aut &&
                 hdr == HEADER_MARK && tail == TAIL_MARK) begin
      last_good_time = now;
      frame_seen     = 1'b1;
      link_up        = 1'b1;
      if (good_frames < FRAME_CNT_MAX) good_frames = good_frames + 16'd1;
      if (tgt == MODE_TARGET) begin
        hold_yaw   = yaw;
        hold_pitch = pitch;
      end
      if (tgt == mode_cand) begin
        if (cand_run < CAND_CNT_MAX) cand_run = cand_run + 8'd1;
      end else begin
        mode_cand = tgt;
        cand_run  = 8'd1;
      end
      need = 8'd1;
      if (mode_settled == MODE_IDLE && mode_cand == MODE_TARGET) need = regs.confirm_01;
      else if (mode_settled == MODE_TARGET && mode_cand == MODE_IDLE) need = regs.confirm_10;
      if (cand_run >= need) mode_settled = mode_cand;
      if (mode_settled == MODE_TARGET) begin
        locked  = 1'b1;
        yaw_w   = yaw;
        pitch_w = pitch;
      end else begin
        locked  = 1'b0;
        yaw_w   = hold_yaw;
        pitch_w = hold_pitch;
      end
    end
    st.online   = link_up;
    st.detected = locked;
    st.mode     = mode_settled;
    st.yaw      = yaw_w;
    st.pitch    = pitch_w;
    st.rate     = rate_w;
    return st;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    link_status_t want;
    if (!rst_n) begin
      regs.confirm_01 = RST_CONFIRM_01;
      regs.confirm_10 = RST_CONFIRM_10;
      regs.timeout    = RST_TIMEOUT;
      regs.window     = RST_WINDOW;
      last_good_time  = '0;
      frame_seen      = 1'b0;
      link_up         = 1'b0;
      locked          = 1'b0;
      mode_settled    = '0;
      mode_cand       = '0;
      cand_run        = '0;
      hold_yaw        = '0;
      hold_pitch      = '0;
      yaw_w           = '0;
      pitch_w         = '0;
      good_frames     = '0;
      rate_w          = '0;
      win_ticks       = '0;
      expected_status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no status expected, got online=%0b mode=%0h",
                   $time, out_online, out_link_mode);
        end else begin
          want = expected_status_q.pop_front();
          compare_field("online", 32'(want.online), 32'(out_online));
          compare_field("detected", 32'(want.detected), 32'(out_detected));
          compare_field("link_mode", 32'(want.mode), 32'(out_link_mode));
          compare_field("yaw_out", want.yaw, out_yaw_out);
          compare_field("pitch_out", want.pitch, out_pitch_out);
          compare_field("frame_rate", 32'(want.rate), 32'(out_frame_rate));
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CONFIRM_01: regs.confirm_01 = cfg_data[7:0];
          CFG_CONFIRM_10: regs.confirm_10 = cfg_data[7:0];
          CFG_TIMEOUT:    regs.timeout    = cfg_data[15:0];
          CFG_WINDOW:     regs.window     = cfg_data[9:0];
          default:        ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_status_q.push_back(advance_link(
          in_mode, in_frame_length, in_header_byte, in_tail_byte, in_target_mode,
          in_yaw_bits, in_pitch_bits, in_time_now,
          in_system_ready, in_vision_ready, in_auto_ready));
      end
    end
    waiting = expected_status_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Top level for the link frame block: clock, reset, stimulus and verdict.
// Directed frames and ticks come first, then random traffic over several
// register settings, a candidate count saturation run and random back-pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lfmd_pkg::*;

  // Item kind carried on in_mode.
  localparam logic ITEM_FRAME = 1'b0;
  localparam logic ITEM_TICK  = 1'b1;

  // Cycles without any transfer on any channel before the run is abandoned.
  // The longest legal quiet stretch is the long receiver hold-off plus a long
  // sender gap and a settling pause, so this is many times over.
  localparam int QUIET_LIMIT = 3000;

  // Number of target frames sent back to back to drive the candidate count
  // into saturation; a little beyond the count's top value.
  localparam int CAND_SAT_FRAMES = 260;

  typedef struct {
    logic        mode;
    logic [15:0] len;
    logic [7:0]  hdr;
    logic [7:0]  tail;
    logic [7:0]  tgt;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] now;
    logic        sys;
    logic        vis;
    logic        aut;
  } link_item_t;

  // Ways in which a frame is made to fail the acceptance checks.
  typedef enum int {
    BREAK_EMPTY,
    BREAK_LENGTH,
    BREAK_HEADER,
    BREAK_TAIL,
    BREAK_SYSTEM,
    BREAK_VISION,
    BREAK_AUTO,
    BREAK_NOISE
  } frame_fault_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [15:0]           in_frame_length;
  logic [7:0]            in_header_byte;
  logic [7:0]            in_tail_byte;
  logic [7:0]            in_target_mode;
  logic [31:0]           in_yaw_bits;
  logic [31:0]           in_pitch_bits;
  logic [31:0]           in_time_now;
  logic                  in_system_ready;
  logic                  in_vision_ready;
  logic                  in_auto_ready;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_online;
  logic                  out_detected;
  logic [7:0]            out_link_mode;
  logic [31:0]           out_yaw_out;
  logic [31:0]           out_pitch_out;
  logic [15:0]           out_frame_rate;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails;
  int pend;
  int results_seen;

  // Stimulus bookkeeping.
  logic [31:0] link_time;
  logic [7:0]  cur_c01;
  logic [7:0]  cur_c10;
  logic [15:0] cur_to;
  int          frames_sent  = 0;
  int          ticks_sent   = 0;
  int          settings_run = 0;
  int          burst        = 0;
  bit          steady       = 1'b0;
  bit          hold_req     = 1'b0;
  link_item_t  item;

  link_frame_mode_debounce_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_frame_length    (in_frame_length),
    .in_header_byte     (in_header_byte),
    .in_tail_byte       (in_tail_byte),
    .in_target_mode     (in_target_mode),
    .in_yaw_bits        (in_yaw_bits),
    .in_pitch_bits      (in_pitch_bits),
    .in_time_now        (in_time_now),
    .in_system_ready    (in_system_ready),
    .in_vision_ready    (in_vision_ready),
    .in_auto_ready      (in_auto_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_online         (out_online),
    .out_detected       (out_detected),
    .out_link_mode      (out_link_mode),
    .out_yaw_out        (out_yaw_out),
    .out_pitch_out      (out_pitch_out),
    .out_frame_rate     (out_frame_rate),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // The checker sits beside the block, sees every transfer and keeps the
  // tally of failures and of statuses still owed by the block.
  lfmd_link_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_frame_length    (in_frame_length),
    .in_header_byte     (in_header_byte),
    .in_tail_byte       (in_tail_byte),
    .in_target_mode     (in_target_mode),
    .in_yaw_bits        (in_yaw_bits),
    .in_pitch_bits      (in_pitch_bits),
    .in_time_now        (in_time_now),
    .in_system_ready    (in_system_ready),
    .in_vision_ready    (in_vision_ready),
    .in_auto_ready      (in_auto_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_online         (out_online),
    .out_detected       (out_detected),
    .out_link_mode      (out_link_mode),
    .out_yaw_out        (out_yaw_out),
    .out_pitch_out      (out_pitch_out),
    .out_frame_rate     (out_frame_rate),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fails),
    .pending            (pend),
    .results_checked    (results_seen)
  );

  // 2 ns clock period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Angle words lean towards the all-zero and all-one patterns now and then.
  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h0000_0000;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // A frame that passes every check, stamped with the current link time.
  function automatic link_item_t good_frame(logic [7:0] tgt);
    link_item_t it;
    it.mode  = ITEM_FRAME;
    it.len   = FRAME_BYTES;
    it.hdr   = HEADER_MARK;
    it.tail  = TAIL_MARK;
    it.tgt   = tgt;
    it.yaw   = rand_word();
    it.pitch = rand_word();
    it.now   = link_time;
    it.sys   = 1'b1;
    it.vis   = 1'b1;
    it.aut   = 1'b1;
    return it;
  endfunction

  // A tick moves the link time on by the given step. The frame fields are
  // meaningless on a tick, so they carry random junk.
  function automatic link_item_t tick_item(logic sys, logic [31:0] step);
    link_item_t it;
    link_time = link_time + step;
    it.mode   = ITEM_TICK;
    it.len    = 16'($urandom);
    it.hdr    = 8'($urandom);
    it.tail   = 8'($urandom);
    it.tgt    = 8'($urandom);
    it.yaw    = $urandom;
    it.pitch  = $urandom;
    it.now    = link_time;
    it.sys    = sys;
    it.vis    = 1'($urandom);
    it.aut    = 1'($urandom);
    return it;
  endfunction

  // A frame spoilt in one of the ways the block must reject, or plain noise.
  function automatic link_item_t broken_frame();
    link_item_t   it;
    frame_fault_t fault;
    it    = good_frame(8'($urandom));
    fault = frame_fault_t'($urandom_range(BREAK_NOISE));
    case (fault)
      BREAK_EMPTY: it.len = '0;
      BREAK_LENGTH: begin
        if ($urandom_range(1)) it.len = $urandom_range(1) ? FRAME_BYTES + 16'd1
                                                          : FRAME_BYTES - 16'd1;
        else it.len = 16'($urandom);
        if (it.len == FRAME_BYTES) it.len = ~FRAME_BYTES;
      end
      BREAK_HEADER: begin
        it.hdr = 8'($urandom);
        if (it.hdr == HEADER_MARK) it.hdr = ~HEADER_MARK;
      end
      BREAK_TAIL: begin
        it.tail = 8'($urandom);
        if (it.tail == TAIL_MARK) it.tail = ~TAIL_MARK;
      end
      BREAK_SYSTEM: it.sys = 1'b0;
      BREAK_VISION: it.vis = 1'b0;
      BREAK_AUTO:   it.aut = 1'b0;
      default: begin
        it.len  = 16'($urandom);
        it.hdr  = 8'($urandom);
        it.tail = 8'($urandom);
        it.sys  = 1'($urandom);
        it.vis  = 1'($urandom);
        it.aut  = 1'($urandom);
      end
    endcase
    return it;
  endfunction

  // Offers one item at a falling edge and holds it until the transfer
  // happens, then leaves a gap of random length unless the traffic is meant
  // to run without idling. With no gap, valid simply stays high for the next
  // item, so it is never lowered and raised within one time step.
  task automatic send_item(link_item_t it);
    int r;
    int gap;
    @(negedge clk);
    in_mode         <= it.mode;
    in_frame_length <= it.len;
    in_header_byte  <= it.hdr;
    in_tail_byte    <= it.tail;
    in_target_mode  <= it.tgt;
    in_yaw_bits     <= it.yaw;
    in_pitch_bits   <= it.pitch;
    in_time_now     <= it.now;
    in_system_ready <= it.sys;
    in_vision_ready <= it.vis;
    in_auto_ready   <= it.aut;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (it.mode == ITEM_TICK) ticks_sent++;
    else frames_sent++;
    gap = 0;
    if (burst > 0) begin
      burst--;
    end else if (!steady) begin
      // Mostly short gaps, now and then a long one.
      r = $urandom_range(99);
      if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 2);
      else if (r < 97) gap = $urandom_range(3, 8);
      else gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stops offering items and waits until every expected status has been
  // delivered, plus a few cycles for the pipeline to go quiet.
  // The checker updates its count on rising edges, so it is read at a
  // falling edge.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pend == 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes all four registers. With junk set, the data bits above the confirm
  // and window widths carry random values, which the block must ignore.
  task automatic write_config(logic [7:0] c01, logic [7:0] c10, logic [15:0] to,
                              logic [9:0] win, bit junk);
    logic [7:0] hi;
    hi = junk ? 8'($urandom) : 8'd0;
    write_reg(CFG_CONFIRM_01, {hi, c01});
    write_reg(CFG_CONFIRM_10, {hi, c10});
    write_reg(CFG_TIMEOUT, to);
    write_reg(CFG_WINDOW, {hi[5:0], win});
    cur_c01 = c01;
    cur_c10 = c10;
    cur_to  = to;
    settings_run++;
  endtask

  // Random traffic for one register setting. Most items are good frames in
  // runs of one mode, at most the larger confirm threshold plus two, with ticks
  // in between; the rest are rejected frames and noise. Only good frames and
  // ticks count towards the target, since a rejected frame changes nothing.
  task automatic run_random(int target);
    int          done;
    int          run_left;
    int          run_cap;
    int          pick;
    int          r;
    logic [31:0] step;
    logic [7:0]  run_mode;
    link_item_t  it;
    run_cap = (cur_c01 > cur_c10 ? int'(cur_c01) : int'(cur_c10)) + 2;
    if (run_cap > 10) run_cap = 10;
    run_left = 0;
    run_mode = MODE_IDLE;
    done     = 0;
    // The receiver holds off for a long stretch while the sender keeps on
    // offering items back to back, so that the block fills up and stalls.
    if (!steady) begin
      hold_req = 1'b1;
      burst    = 12;
    end
    while (done < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (run_left == 0) begin
          r = $urandom_range(99);
          if (r < 45) run_mode = MODE_IDLE;
          else if (r < 90) run_mode = MODE_TARGET;
          else run_mode = 8'($urandom);
          run_left = $urandom_range(1, run_cap);
        end
        run_left--;
        it = good_frame(run_mode);
        done++;
      end else if (pick < 85) begin
        // Time mostly advances one tick at a time so that the timeout
        // boundary is crossed exactly; sometimes it jumps, now and then to
        // anywhere at all, wrap-around included.
        r = $urandom_range(99);
        if (r < 80) step = 32'd1;
        else if (r < 92) step = $urandom_range(0, 4);
        else if (r < 97) step = $urandom_range(0, 2 * int'(cur_to) + 2);
        else step = $urandom;
        it = tick_item($urandom_range(99) >= 6, step);
        done++;
      end else begin
        it = broken_frame();
      end
      send_item(it);
    end
  endtask

  // Receiver: random stretches of readiness and stall, decided at each
  // falling edge. A hold-off request from the stimulus takes priority and is
  // counted out here, in cycles of this process.
  initial begin : result_sink
    int quiet;
    int busy;
    int r;
    quiet     = 0;
    busy      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        quiet    = 60;
        busy     = 0;
      end
      if (quiet == 0 && busy == 0) begin
        r = $urandom_range(99);
        if (r < 55) busy = $urandom_range(1, 20);
        else if (r < 85) quiet = $urandom_range(1, 3);
        else if (r < 97) quiet = $urandom_range(4, 10);
        else quiet = $urandom_range(20, 40);
      end
      if (steady) begin
        out_ready <= 1'b1;
      end else if (quiet > 0) begin
        quiet--;
        out_ready <= 1'b0;
      end else begin
        busy--;
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run is abandoned once the stretch of idle cycles, with no
  // transfer of any kind and reset released, reaches QUIET_LIMIT.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: watchdog, no transfer for %0d cycles, %0d statuses outstanding",
             $time, QUIET_LIMIT, pend);
    $display("tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int p;
    int i;
    // Every input is known from the first instant; reset is held from the start
    // and released at a falling edge, never to be asserted again.
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = ITEM_FRAME;
    in_frame_length = '0;
    in_header_byte  = '0;
    in_tail_byte    = '0;
    in_target_mode  = '0;
    in_yaw_bits     = '0;
    in_pitch_bits   = '0;
    in_time_now     = '0;
    in_system_ready = 1'b0;
    in_vision_ready = 1'b0;
    in_auto_ready   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_CONFIRM_01;
    cfg_data        = '0;
    cur_c01         = RST_CONFIRM_01;
    cur_c10         = RST_CONFIRM_10;
    cur_to          = RST_TIMEOUT;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed part, with the registers at their reset values ----
    // Start just below the wrap of the time counter so that the timeout
    // arithmetic has to work modulo 2^32.
    link_time = 32'hFFFF_FFF0;
    // A tick before any frame has been seen keeps the link offline.
    send_item(tick_item(1'b1, 32'd1));
    // Every way of rejecting a frame, each on an otherwise good frame.
    item = good_frame(MODE_TARGET); item.len = '0;            send_item(item);
    item = good_frame(MODE_TARGET); item.vis = 1'b0;          send_item(item);
    item = good_frame(MODE_TARGET); item.aut = 1'b0;          send_item(item);
    item = good_frame(MODE_TARGET); item.sys = 1'b0;          send_item(item);
    item = good_frame(MODE_TARGET); item.len = FRAME_BYTES + 16'd1; send_item(item);
    item = good_frame(MODE_TARGET); item.len = 16'hFFFF;      send_item(item);
    item = good_frame(MODE_TARGET); item.hdr = 8'h00;         send_item(item);
    item = good_frame(MODE_TARGET); item.tail = 8'hFF;        send_item(item);
    // Three target frames confirm the switch from idle to target; the angle
    // words take their extreme values on the way.
    item = good_frame(MODE_TARGET);
    item.yaw   = 32'hFFFF_FFFF;
    item.pitch = 32'h0000_0000;
    send_item(item);
    item = good_frame(MODE_TARGET);
    item.yaw   = 32'h0000_0000;
    item.pitch = 32'hFFFF_FFFF;
    send_item(item);
    send_item(good_frame(MODE_TARGET));
    // A tick across the wrap of the time counter, well inside the timeout.
    send_item(tick_item(1'b1, 32'd20));
    // Three idle frames confirm the switch back; held angles are shown.
    send_item(good_frame(MODE_IDLE));
    send_item(good_frame(MODE_IDLE));
    send_item(good_frame(MODE_IDLE));
    // Mode values other than idle and target settle after a single frame.
    send_item(good_frame(8'd2));
    send_item(good_frame(8'hFF));
    // Exactly at the timeout the link stays online; one tick later it drops.
    send_item(tick_item(1'b1, 32'd100));
    send_item(tick_item(1'b1, 32'd1));
    // A tick without the system ready flag clears the link and the meter.
    send_item(tick_item(1'b0, 32'd1));
    send_item(good_frame(MODE_TARGET));
    send_item(tick_item(1'b1, 32'd1));

    // ---- Random part over several register settings ----
    link_time = $urandom;
    for (p = 0; p < 9; p++) begin
      drain();
      case (p)
        // Lowest values: thresholds of zero, no timeout slack, zero window.
        0: write_config(8'd0, 8'd0, 16'd0, 10'd0, 1'b0);
        // Highest values, with junk above the confirm and window widths.
        1: write_config(8'd255, 8'd255, 16'hFFFF, 10'd1023, 1'b1);
        2: write_config(8'd1, 8'd1, 16'd5, 10'd4, 1'b0);
        default: write_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                              16'($urandom_range(0, 30)),
                              ($urandom_range(99) < 20) ? 10'd1000
                                                        : 10'($urandom_range(1, 20)),
                              1'($urandom));
      endcase
      // One setting runs entirely without idling on either side.
      steady = (p == 2);
      run_random(56);
      steady = 1'b0;
    end

    // ---- Candidate count saturation ----
    // A long run of target frames pushes the candidate count to its limit,
    // confirming the switch at the highest threshold, and the count must
    // then stay at its top value.
    drain();
    write_config(8'd255, 8'd1, 16'hFFFF, 10'd1023, 1'b0);
    steady = 1'b1;
    send_item(tick_item(1'b0, 32'd1));
    send_item(good_frame(MODE_IDLE));
    send_item(good_frame(MODE_IDLE));
    for (i = 0; i < CAND_SAT_FRAMES; i++) send_item(good_frame(MODE_TARGET));
    steady = 1'b0;
    // A one-tick window then publishes the frame count as the rate.
    drain();
    write_reg(CFG_WINDOW, 16'd1);
    send_item(tick_item(1'b1, 32'd1));

    // ---- A last random setting near the reset values ----
    drain();
    write_config(8'd3, 8'd3, 16'd100, 10'd20, 1'b0);
    run_random(56);

    // All stimulus is in: wait for the last statuses, then a few more cycles
    // in case anything unexpected is still to come out.
    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d frames and %0d ticks; %0d result transfers checked.",
             frames_sent, ticks_sent, results_seen);
    $display("Covered %0d register settings, timeouts, rate windows and count saturation.",
             settings_run);
    if (fails == 0 && pend == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
